// File: hdl/ios_pkg.sv
package ios_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int NUM_REGS_DEF  = 32;
    localparam int MAX_SRCS_DEF  = 3;
    localparam int MAX_ISSUE_DEF = 4;

    localparam int TAG_W      = 32;
    localparam int REG_W      = 5;
    localparam int CFG_W      = 5;
    localparam int SRC_FIELDS = 3;

    localparam logic CFG_ISSUE_WIDTH = 1'b0;
    localparam logic CFG_CAPACITY    = 1'b1;

    localparam logic [2:0] ISSUE_WIDTH_RST = 3'd1;
    localparam logic [4:0] CAPACITY_RST    = 5'd16;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_ISSUE   = 2'd1,
        OP_READY   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ENQUEUED    = 3'd0,
        KIND_REFUSED     = 3'd1,
        KIND_ISSUED      = 3'd2,
        KIND_NONE_ISSUED = 3'd3,
        KIND_RELEASED    = 3'd4,
        KIND_EMPTY       = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_CHK,
        ST_REL_OUT
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]                 tag;
        logic [REG_W-1:0]                 dest;
        logic [1:0]                       src_cnt;
        logic [SRC_FIELDS-1:0][REG_W-1:0] src;
    } entry_t;

endpackage

// File: hdl/ios_entry_ram.sv
module ios_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 54
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/in_order_issue_scoreboard_top.sv
// In-order issue scoreboard.
// Command channel: present opcode and fields with start high; the command is
// taken at a rising edge where start is high and busy is low. Configuration
// channel: cfg_valid/cfg_ready with cfg_index (0 issue width, 1 capacity) and
// cfg_data; cfg_ready is always high. Write it only while the block is idle.
// Results appear for one cycle with result_valid high; last marks the final
// result of a command. The receiver cannot stall, so every result is taken.
// Enqueue and register ready leave the block idle; an enqueue result
// appears in the cycle after the command is taken, register ready gives
// none. A release reads the head entry from the entry RAM first and
// emits it from state REL_OUT. An issue pass walks the queue from the
// head: an issued entry is skipped, an unissued one gets one registered
// read of the entry RAM in WALK, then one readiness check of its sources
// in WALK_CHK; the pass stops at an entry whose sources are not ready.
// An issued result is held in the pend registers until the walk knows
// whether it is the last one. Reset clears the queue, the issued marks,
// sets every register ready and loads issue width 1 and capacity 16;
// entry contents stay undefined until written.
module in_order_issue_scoreboard_top #(
    parameter int DEPTH     = ios_pkg::DEPTH_DEF,
    parameter int NUM_REGS  = ios_pkg::NUM_REGS_DEF,
    parameter int MAX_SRCS  = ios_pkg::MAX_SRCS_DEF,
    parameter int MAX_ISSUE = ios_pkg::MAX_ISSUE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [ios_pkg::TAG_W-1:0] instr_tag,
    input  logic [ios_pkg::REG_W-1:0] dest_reg,
    input  logic [1:0]                src_count,
    input  logic [ios_pkg::REG_W-1:0] src_a,
    input  logic [ios_pkg::REG_W-1:0] src_b,
    input  logic [ios_pkg::REG_W-1:0] src_c,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [ios_pkg::CFG_W-1:0] cfg_data,
    output logic                      result_valid,
    output logic [2:0]                kind,
    output logic [ios_pkg::TAG_W-1:0] tag_out,
    output logic [ios_pkg::REG_W-1:0] dest_out,
    output logic                      last,
    output logic [4:0]                occupancy
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int NW   = $clog2(MAX_ISSUE + 1);
    localparam int RIW  = $clog2(NUM_REGS);
    localparam int CMPW = (CNTW > 5) ? CNTW : 5;
    localparam int EW   = $bits(ios_pkg::entry_t);
    localparam logic [PTRW-1:0] PTR_MAX = PTRW'(DEPTH - 1);

    ios_pkg::state_t state_reg, state_next;

    logic [PTRW-1:0]     head_reg, head_next;
    logic [PTRW-1:0]     tail_reg, tail_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [DEPTH-1:0]    issued_reg, issued_next;
    logic [NUM_REGS-1:0] ready_reg, ready_next;
    logic [2:0]          issue_width_reg, issue_width_next;
    logic [4:0]          capacity_reg, capacity_next;

    logic [PTRW-1:0] ptr_reg, ptr_next;
    logic [CNTW-1:0] walk_reg, walk_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   width_reg, width_next;

    logic                      pend_valid_reg, pend_valid_next;
    logic [ios_pkg::TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic [ios_pkg::REG_W-1:0] pend_dest_reg, pend_dest_next;

    logic                      out_valid_reg, out_valid_next;
    logic [2:0]                out_kind_reg, out_kind_next;
    logic [ios_pkg::TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [ios_pkg::REG_W-1:0] out_dest_reg, out_dest_next;
    logic                      out_last_reg, out_last_next;
    logic [4:0]                out_occ_reg, out_occ_next;

    logic            ram_wr_en;
    logic            ram_rd_en;
    logic [PTRW-1:0] ram_rd_addr;
    logic [EW-1:0]   ram_rd_data;
    ios_pkg::entry_t wr_entry;
    ios_pkg::entry_t rd_entry;

    logic            accept;
    logic            full;
    logic            srcs_ok;
    logic [3:0]      width_raw;

    function automatic logic src_ok(input logic [ios_pkg::REG_W-1:0] r,
                                    input logic [NUM_REGS-1:0] rdy);
        logic res;
        res = 1'b1;
        if (int'(r) < NUM_REGS)
        begin
            res = rdy[RIW'(r)];
        end
        return res;
    endfunction

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        return (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != ios_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rd_entry  = ios_pkg::entry_t'(ram_rd_data);
    assign full      = (CMPW'(count_reg) >= CMPW'(capacity_reg))
                       || (count_reg == CNTW'(DEPTH));
    assign width_raw = {1'b0, issue_width_reg};

    always_comb
    begin
        wr_entry.tag     = instr_tag;
        wr_entry.dest    = dest_reg;
        wr_entry.src_cnt = (int'(src_count) > MAX_SRCS) ? 2'(MAX_SRCS) : src_count;
        wr_entry.src[0]  = src_a;
        wr_entry.src[1]  = src_b;
        wr_entry.src[2]  = src_c;
    end

    // Readiness check of the sources of the entry just read from the RAM.
    always_comb
    begin
        srcs_ok = 1'b1;
        for (int i = 0; i < ios_pkg::SRC_FIELDS; i++)
        begin
            if ((2'(i) < rd_entry.src_cnt) && !src_ok(rd_entry.src[i], ready_reg))
            begin
                srcs_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        issued_next      = issued_reg;
        ready_next       = ready_reg;
        issue_width_next = issue_width_reg;
        capacity_next    = capacity_reg;
        ptr_next         = ptr_reg;
        walk_next        = walk_reg;
        n_next           = n_reg;
        width_next       = width_reg;
        pend_valid_next  = pend_valid_reg;
        pend_tag_next    = pend_tag_reg;
        pend_dest_next   = pend_dest_reg;
        out_valid_next   = 1'b0;
        out_kind_next    = out_kind_reg;
        out_tag_next     = out_tag_reg;
        out_dest_next    = out_dest_reg;
        out_last_next    = out_last_reg;
        out_occ_next     = out_occ_reg;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = ptr_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ios_pkg::CFG_ISSUE_WIDTH: issue_width_next = cfg_data[2:0];
                ios_pkg::CFG_CAPACITY:    capacity_next    = cfg_data;
                default:                  ;
            endcase
        end

        case (state_reg)
            ios_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (ios_pkg::op_t'(opcode))
                        ios_pkg::OP_ENQUEUE:
                        begin
                            out_valid_next = 1'b1;
                            out_tag_next   = '0;
                            out_dest_next  = '0;
                            out_last_next  = 1'b1;
                            if (full)
                            begin
                                out_kind_next = ios_pkg::KIND_REFUSED;
                                out_occ_next  = 5'(count_reg);
                            end
                            else
                            begin
                                ram_wr_en             = 1'b1;
                                issued_next[tail_reg] = 1'b0;
                                tail_next             = ptr_inc(tail_reg);
                                count_next            = count_reg + 1'b1;
                                out_kind_next         = ios_pkg::KIND_ENQUEUED;
                                out_occ_next          = 5'(count_reg + 1'b1);
                            end
                        end
                        ios_pkg::OP_ISSUE:
                        begin
                            if (width_raw == 4'd0)
                            begin
                                width_next = NW'(1);
                            end
                            else if (int'(width_raw) > MAX_ISSUE)
                            begin
                                width_next = NW'(MAX_ISSUE);
                            end
                            else
                            begin
                                width_next = NW'(width_raw);
                            end
                            ptr_next        = head_reg;
                            walk_next       = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ios_pkg::ST_WALK;
                        end
                        ios_pkg::OP_READY:
                        begin
                            if (int'(dest_reg) < NUM_REGS)
                            begin
                                ready_next[RIW'(dest_reg)] = 1'b1;
                            end
                        end
                        ios_pkg::OP_RELEASE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ios_pkg::KIND_EMPTY;
                                out_tag_next   = '0;
                                out_dest_next  = '0;
                                out_last_next  = 1'b1;
                                out_occ_next   = 5'(count_reg);
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                state_next  = ios_pkg::ST_REL_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ios_pkg::ST_REL_OUT:
            begin
                out_valid_next        = 1'b1;
                out_kind_next         = ios_pkg::KIND_RELEASED;
                out_tag_next          = rd_entry.tag;
                out_dest_next         = rd_entry.dest;
                out_last_next         = 1'b1;
                out_occ_next          = 5'(count_reg - 1'b1);
                issued_next[head_reg] = 1'b0;
                head_next             = ptr_inc(head_reg);
                count_next            = count_reg - 1'b1;
                state_next            = ios_pkg::ST_IDLE;
            end

            ios_pkg::ST_WALK:
            begin
                if ((walk_reg >= count_reg) || (n_reg >= width_reg))
                begin
                    state_next = ios_pkg::ST_IDLE;
                end
                else if (issued_reg[ptr_reg])
                begin
                    ptr_next  = ptr_inc(ptr_reg);
                    walk_next = walk_reg + 1'b1;
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ios_pkg::ST_WALK_CHK;
                end
            end

            ios_pkg::ST_WALK_CHK:
            begin
                if (!srcs_ok)
                begin
                    state_next = ios_pkg::ST_IDLE;
                end
                else
                begin
                    issued_next[ptr_reg] = 1'b1;
                    if (int'(rd_entry.dest) < NUM_REGS)
                    begin
                        ready_next[RIW'(rd_entry.dest)] = 1'b0;
                    end
                    // Flush the held result: another one follows it.
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = ios_pkg::KIND_ISSUED;
                        out_tag_next   = pend_tag_reg;
                        out_dest_next  = pend_dest_reg;
                        out_last_next  = 1'b0;
                        out_occ_next   = 5'(count_reg);
                    end
                    pend_valid_next = 1'b1;
                    pend_tag_next   = rd_entry.tag;
                    pend_dest_next  = rd_entry.dest;
                    n_next          = n_reg + 1'b1;
                    ptr_next        = ptr_inc(ptr_reg);
                    walk_next       = walk_reg + 1'b1;
                    state_next      = ios_pkg::ST_WALK;
                end
            end

            default:
            begin
                state_next = ios_pkg::ST_IDLE;
            end
        endcase

        // End of an issue pass: emit the held result as last, or report none.
        if (busy && (state_next == ios_pkg::ST_IDLE) && (state_reg != ios_pkg::ST_REL_OUT))
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_occ_next   = 5'(count_reg);
            if (pend_valid_reg)
            begin
                out_kind_next = ios_pkg::KIND_ISSUED;
                out_tag_next  = pend_tag_reg;
                out_dest_next = pend_dest_reg;
            end
            else
            begin
                out_kind_next = ios_pkg::KIND_NONE_ISSUED;
                out_tag_next  = '0;
                out_dest_next = '0;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ios_pkg::ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            issued_reg      <= '0;
            ready_reg       <= '1;
            issue_width_reg <= ios_pkg::ISSUE_WIDTH_RST;
            capacity_reg    <= ios_pkg::CAPACITY_RST;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            issued_reg      <= issued_next;
            ready_reg       <= ready_next;
            issue_width_reg <= issue_width_next;
            capacity_reg    <= capacity_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        walk_reg      <= walk_next;
        n_reg         <= n_next;
        width_reg     <= width_next;
        pend_tag_reg  <= pend_tag_next;
        pend_dest_reg <= pend_dest_next;
        out_kind_reg  <= out_kind_next;
        out_tag_reg   <= out_tag_next;
        out_dest_reg  <= out_dest_next;
        out_last_reg  <= out_last_next;
        out_occ_reg   <= out_occ_next;
    end

    ios_entry_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign tag_out      = out_tag_reg;
    assign dest_out     = out_dest_reg;
    assign last         = out_last_reg;
    assign occupancy    = out_occ_reg;

endmodule

// File: hdl/ios_checker.sv
module ios_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                opcode,
    input logic                      result_valid,
    input logic [2:0]                kind,
    input logic [ios_pkg::TAG_W-1:0] tag_out,
    input logic [ios_pkg::REG_W-1:0] dest_out,
    input logic                      last,
    input logic [4:0]                occupancy
);

    // An accepted issue command raises busy in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == ios_pkg::OP_ISSUE) |=> busy)
        else $error("issue pass accepted without going busy");

    // More results of the same transaction are still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

    // Only issued results come in groups.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != ios_pkg::KIND_ISSUED) |-> last)
        else $error("single-result kind without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((kind == ios_pkg::KIND_ENQUEUED) || (kind == ios_pkg::KIND_REFUSED)
        || (kind == ios_pkg::KIND_NONE_ISSUED) || (kind == ios_pkg::KIND_EMPTY))
        |-> (tag_out == '0) && (dest_out == '0))
        else $error("entry fields on a result without an entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == ios_pkg::KIND_ENQUEUED) |-> (occupancy != 5'd0))
        else $error("enqueue reported an empty queue");

endmodule

bind in_order_issue_scoreboard_top ios_checker u_ios_checker (.*);

// File: dv/in_order_issue_scoreboard_top_tb.sv
`timescale 1ns / 1ps

module in_order_issue_scoreboard_top_tb;

    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENTS      = 7;

    typedef struct packed {
        ios_pkg::kind_t                kind;
        logic [ios_pkg::TAG_W-1:0]     tag;
        logic [ios_pkg::REG_W-1:0]     dest;
        logic                          last;
        logic [4:0]                    occupancy;
    } result_t;

    class issue_tracker;
        logic [ios_pkg::TAG_W-1:0] ent_tag   [ios_pkg::DEPTH_DEF];
        logic [ios_pkg::REG_W-1:0] ent_dest  [ios_pkg::DEPTH_DEF];
        int                        ent_nsrc  [ios_pkg::DEPTH_DEF];
        logic [ios_pkg::REG_W-1:0] ent_src   [ios_pkg::DEPTH_DEF][ios_pkg::SRC_FIELDS];
        bit                        ent_issued[ios_pkg::DEPTH_DEF];
        bit                        reg_ready [ios_pkg::NUM_REGS_DEF];
        int                        head_slot;
        int                        held;
        int                        issue_width;
        int                        capacity;
        result_t                   pending[$];
        int                        errors;

        function new();
            for (int i = 0; i < ios_pkg::DEPTH_DEF; i++)
                ent_issued[i] = 1'b0;
            for (int r = 0; r < ios_pkg::NUM_REGS_DEF; r++)
                reg_ready[r] = 1'b1;
            head_slot   = 0;
            held        = 0;
            issue_width = int'(ios_pkg::ISSUE_WIDTH_RST);
            capacity    = int'(ios_pkg::CAPACITY_RST);
            errors      = 0;
        endfunction

        function void add_row(result_t r);
            pending = {pending, r};
        endfunction

        function void write_reg(logic idx, logic [ios_pkg::CFG_W-1:0] data);
            if (idx == ios_pkg::CFG_ISSUE_WIDTH)
                issue_width = int'(data[2:0]);
            else
                capacity = int'(data);
        endfunction

        function bit sources_ready(int slot);
            for (int i = 0; i < ent_nsrc[slot]; i++)
                if (!reg_ready[ent_src[slot][i]])
                    return 1'b0;
            return 1'b1;
        endfunction

        function result_t row(ios_pkg::kind_t k, logic [ios_pkg::TAG_W-1:0] t,
                              logic [ios_pkg::REG_W-1:0] d, logic l);
            result_t r;
            r.kind      = k;
            r.tag       = t;
            r.dest      = d;
            r.last      = l;
            r.occupancy = held[4:0];
            return r;
        endfunction

        function void take_command(ios_pkg::op_t op, logic [ios_pkg::TAG_W-1:0] tag,
                                   logic [ios_pkg::REG_W-1:0] dest,
                                   logic [1:0] n_src, logic [ios_pkg::REG_W-1:0] src0,
                                   logic [ios_pkg::REG_W-1:0] src1,
                                   logic [ios_pkg::REG_W-1:0] src2);
            int      slot;
            int      width;
            int      n;
            result_t staged;
            case (op)
                ios_pkg::OP_ENQUEUE:
                begin
                    if (held >= capacity || held >= ios_pkg::DEPTH_DEF)
                    begin
                        add_row(row(ios_pkg::KIND_REFUSED, '0, '0, 1'b1));
                    end
                    else
                    begin
                        slot = (head_slot + held) % ios_pkg::DEPTH_DEF;
                        ent_tag[slot]    = tag;
                        ent_dest[slot]   = dest;
                        ent_nsrc[slot]   = (int'(n_src) > ios_pkg::MAX_SRCS_DEF) ?
                                           ios_pkg::MAX_SRCS_DEF : int'(n_src);
                        ent_src[slot][0] = src0;
                        ent_src[slot][1] = src1;
                        ent_src[slot][2] = src2;
                        ent_issued[slot] = 1'b0;
                        held++;
                        add_row(row(ios_pkg::KIND_ENQUEUED, '0, '0, 1'b1));
                    end
                end
                ios_pkg::OP_ISSUE:
                begin
                    width = issue_width;
                    if (width < 1)
                        width = 1;
                    if (width > ios_pkg::MAX_ISSUE_DEF)
                        width = ios_pkg::MAX_ISSUE_DEF;
                    n = 0;
                    for (int i = 0; i < held && n < width; i++)
                    begin
                        slot = (head_slot + i) % ios_pkg::DEPTH_DEF;
                        if (ent_issued[slot])
                            continue;
                        if (!sources_ready(slot))
                            break;
                        ent_issued[slot] = 1'b1;
                        reg_ready[ent_dest[slot]] = 1'b0;
                        // hold each issue until the walk knows whether it is the final one
                        if (n > 0)
                            add_row(staged);
                        staged = row(ios_pkg::KIND_ISSUED, ent_tag[slot], ent_dest[slot], 1'b0);
                        n++;
                    end
                    if (n == 0)
                    begin
                        add_row(row(ios_pkg::KIND_NONE_ISSUED, '0, '0, 1'b1));
                    end
                    else
                    begin
                        staged.last = 1'b1;
                        add_row(staged);
                    end
                end
                ios_pkg::OP_READY:
                begin
                    reg_ready[dest] = 1'b1;
                end
                default:
                begin
                    if (held == 0)
                    begin
                        add_row(row(ios_pkg::KIND_EMPTY, '0, '0, 1'b1));
                    end
                    else
                    begin
                        slot = head_slot;
                        ent_issued[slot] = 1'b0;
                        head_slot = (head_slot + 1) % ios_pkg::DEPTH_DEF;
                        held--;
                        add_row(row(ios_pkg::KIND_RELEASED, ent_tag[slot], ent_dest[slot],
                                    1'b1));
                    end
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: kind %0d tag %h dest %0d last %0d occ %0d",
                             got.kind, got.tag, got.dest, got.last, got.occupancy);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.tag !== want.tag || got.dest !== want.dest ||
                got.last !== want.last || got.occupancy !== want.occupancy)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected kind %0d tag %h dest %0d last %0d occ %0d,",
                              " got kind %0d tag %h dest %0d last %0d occ %0d"},
                             want.kind, want.tag, want.dest, want.last, want.occupancy,
                             got.kind, got.tag, got.dest, got.last, got.occupancy);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                opcode;
    logic [ios_pkg::TAG_W-1:0] instr_tag;
    logic [ios_pkg::REG_W-1:0] dest_reg;
    logic [1:0]                src_count;
    logic [ios_pkg::REG_W-1:0] src_a;
    logic [ios_pkg::REG_W-1:0] src_b;
    logic [ios_pkg::REG_W-1:0] src_c;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [ios_pkg::CFG_W-1:0] cfg_data;
    logic                      result_valid;
    logic [2:0]                kind;
    logic [ios_pkg::TAG_W-1:0] tag_out;
    logic [ios_pkg::REG_W-1:0] dest_out;
    logic                      last;
    logic [4:0]                occupancy;

    issue_tracker tracker;
    int           idle_pct;
    int           cycles = 0;

    logic [ios_pkg::CFG_W-1:0] width_plan [SEGMENTS] = '{5'd4, 5'd0, 5'd30, 5'd2, 5'd7, 5'd3,
                                                         5'd1};
    logic [ios_pkg::CFG_W-1:0] cap_plan   [SEGMENTS] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12,
                                                         5'd16};
    int                        items_plan [SEGMENTS] = '{50, 45, 50, 15, 50, 50, 50};

    in_order_issue_scoreboard_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .instr_tag    (instr_tag),
        .dest_reg     (dest_reg),
        .src_count    (src_count),
        .src_a        (src_a),
        .src_b        (src_b),
        .src_c        (src_c),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .kind         (kind),
        .tag_out      (tag_out),
        .dest_out     (dest_out),
        .last         (last),
        .occupancy    (occupancy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_result('{ios_pkg::kind_t'(kind), tag_out, dest_out, last, occupancy});
    end

    function automatic logic [ios_pkg::REG_W-1:0] rand_reg();
        logic [31:0] v;
        v = $urandom;
        return v[ios_pkg::REG_W-1:0];
    endfunction

    function automatic logic [1:0] rand_cnt();
        logic [31:0] v;
        v = $urandom;
        return v[1:0];
    endfunction

    task automatic send_command(ios_pkg::op_t op, logic [ios_pkg::TAG_W-1:0] tag,
                                logic [ios_pkg::REG_W-1:0] dest,
                                logic [1:0] n_src, logic [ios_pkg::REG_W-1:0] s0,
                                logic [ios_pkg::REG_W-1:0] s1,
                                logic [ios_pkg::REG_W-1:0] s2);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        opcode    <= op;
        instr_tag <= tag;
        dest_reg  <= dest;
        src_count <= n_src;
        src_a     <= s0;
        src_b     <= s1;
        src_c     <= s2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.take_command(op, tag, dest, n_src, s0, s1, s2);
    endtask

    // drop start, wait for every expected transaction, then let the walk wind down
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [ios_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ios_pkg::REG_W-1:0] pick_reg();
        logic [31:0] v;
        // mostly a small pool so dependencies actually form
        if ($urandom_range(99) < 75)
            v = $urandom_range(7);
        else
            v = $urandom;
        return v[ios_pkg::REG_W-1:0];
    endfunction

    task automatic random_command();
        int                        pick;
        int                        first;
        int                        idx;
        ios_pkg::op_t              op;
        logic [ios_pkg::REG_W-1:0] dest;
        pick = $urandom_range(99);
        dest = pick_reg();
        if (pick < 32)
        begin
            op = ios_pkg::OP_ENQUEUE;
        end
        else if (pick < 60)
        begin
            op = ios_pkg::OP_ISSUE;
        end
        else if (pick < 76)
        begin
            op = ios_pkg::OP_READY;
            // usually wake a register that some instruction is waiting on
            if ($urandom_range(99) < 75)
            begin
                first = $urandom_range(ios_pkg::NUM_REGS_DEF - 1);
                for (int k = 0; k < ios_pkg::NUM_REGS_DEF; k++)
                begin
                    idx = (first + k) % ios_pkg::NUM_REGS_DEF;
                    if (!tracker.reg_ready[idx])
                    begin
                        dest = idx[ios_pkg::REG_W-1:0];
                        break;
                    end
                end
            end
        end
        else
        begin
            op = ios_pkg::OP_RELEASE;
        end
        send_command(op, $urandom, dest, rand_cnt(), pick_reg(), pick_reg(), pick_reg());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = ios_pkg::OP_ENQUEUE;
        instr_tag = '0;
        dest_reg  = '0;
        src_count = '0;
        src_a     = '0;
        src_b     = '0;
        src_c     = '0;
        cfg_valid = 1'b0;
        cfg_index = ios_pkg::CFG_ISSUE_WIDTH;
        cfg_data  = '0;
        idle_pct  = 13;
        tracker   = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, dependency stall, skip of issued entries, release
        send_command(ios_pkg::OP_RELEASE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_READY, $urandom, 5'd5, rand_cnt(), rand_reg(), rand_reg(),
                     rand_reg());
        send_command(ios_pkg::OP_ENQUEUE, 32'h0000_0000, 5'd0, 2'd0, 5'd0, 5'd0, 5'd0);
        send_command(ios_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 5'd31, 2'd3, 5'd31, 5'd0, 5'd31);
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_READY, $urandom, 5'd0, rand_cnt(), rand_reg(), rand_reg(),
                     rand_reg());
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 5'd7, 2'd2, 5'd31, 5'd7, 5'd0);
        send_command(ios_pkg::OP_ENQUEUE, 32'hA5A5_A5A5, 5'd12, 2'd1, 5'd3, 5'd31, 5'd31);
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_READY, $urandom, 5'd31, rand_cnt(), rand_reg(), rand_reg(),
                     rand_reg());
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        send_command(ios_pkg::OP_ENQUEUE, 32'h8000_0001, 5'd31, 2'd3, 5'd12, 5'd7, 5'd31);
        send_command(ios_pkg::OP_ISSUE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                     rand_reg(), rand_reg());
        repeat (5)
            send_command(ios_pkg::OP_RELEASE, $urandom, rand_reg(), rand_cnt(), rand_reg(),
                         rand_reg(), rand_reg());

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            write_config(ios_pkg::CFG_ISSUE_WIDTH, width_plan[seg]);
            write_config(ios_pkg::CFG_CAPACITY, cap_plan[seg]);
            idle_pct = (seg < 2) ? 13 : (seg < 4) ? 70 : 0;
            repeat (items_plan[seg])
                random_command();
        end

        settle();
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
